### design/slx_pkg.sv
// ----------------------------------------------------------------------------
// slx_pkg: shared types, constants and helpers for the script lexer
// Character codes, token kinds, scan modes, the keyword table and the
// token/bundle structs passed between the front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package slx_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int LINE_BITS_DEF   = 24;
  localparam int FIELD_BITS      = 24;
  localparam int QDEPTH          = 4;
  localparam int QPTR_BITS       = $clog2(QDEPTH);
  localparam int MAX_RES         = 3;
  localparam int NUM_CAND        = 6;

  // scan modes
  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_OP       = 4'd1,
    M_SLASH    = 4'd2,
    M_COMMENT  = 4'd3,
    M_STRING   = 4'd4,
    M_NUMBER   = 4'd5,
    M_NUMDOT   = 4'd6,
    M_FRACTION = 4'd7,
    M_IDENT    = 4'd8
  } scan_mode_t;

  // token kinds
  localparam logic [5:0] K_LPAREN   = 6'd0;
  localparam logic [5:0] K_RPAREN   = 6'd1;
  localparam logic [5:0] K_LBRACE   = 6'd2;
  localparam logic [5:0] K_RBRACE   = 6'd3;
  localparam logic [5:0] K_COMMA    = 6'd4;
  localparam logic [5:0] K_DOT      = 6'd5;
  localparam logic [5:0] K_MINUS    = 6'd6;
  localparam logic [5:0] K_PLUS     = 6'd7;
  localparam logic [5:0] K_SEMI     = 6'd8;
  localparam logic [5:0] K_SLASH    = 6'd9;
  localparam logic [5:0] K_STAR     = 6'd10;
  localparam logic [5:0] K_OP0      = 6'd11;
  localparam logic [5:0] K_IDENT    = 6'd19;
  localparam logic [5:0] K_STRING   = 6'd20;
  localparam logic [5:0] K_NUMBER   = 6'd21;
  localparam logic [5:0] K_KEYWORD0 = 6'd22;
  localparam logic [5:0] K_END      = 6'd38;

  // error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_UNEXP   = 2'd1;
  localparam logic [1:0] E_UNTERM  = 2'd2;

  // pending operator codes
  localparam logic [1:0] P_BANG    = 2'd0;
  localparam logic [1:0] P_EQUAL   = 2'd1;
  localparam logic [1:0] P_GREATER = 2'd2;
  localparam logic [1:0] P_LESS    = 2'd3;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  // keyword table, packed big-endian in the low bytes
  localparam logic [47:0] KW_FULL [16] = '{
    48'h000000616e64, 48'h00636c617373, 48'h0000656c7365, 48'h0066616c7365,
    48'h000000666f72, 48'h00000066756e, 48'h000000006966, 48'h0000006e696c,
    48'h000000006f72, 48'h007072696e74, 48'h72657475726e, 48'h007375706572,
    48'h000074686973, 48'h000074727565, 48'h000000766172, 48'h007768696c65
  };

  typedef struct packed {
    logic [5:0]            kind;
    logic [1:0]            err;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] len;
    logic [FIELD_BITS-1:0] line;
  } token_t;

  // up to three results caused by one byte
  typedef struct packed {
    logic [1:0]               cnt;
    token_t [MAX_RES-1:0]     toks;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic single_valid(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_COMMA) || (c == CH_DOT) ||
           (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SEMI) || (c == CH_STAR);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    k = K_LPAREN;
    unique case (c)
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_COMMA:  k = K_COMMA;
      CH_DOT:    k = K_DOT;
      CH_MINUS:  k = K_MINUS;
      CH_PLUS:   k = K_PLUS;
      CH_SEMI:   k = K_SEMI;
      CH_STAR:   k = K_STAR;
      default:   k = K_LPAREN;
    endcase
    return k;
  endfunction

  // identifier or keyword kind from the packed tail of the identifier
  function automatic logic [5:0] ident_kind(input logic [47:0] kb, input logic ovl);
    logic [5:0] k;
    k = K_IDENT;
    if (!ovl) begin
      for (int i = 0; i < 16; i++) begin
        if (kb == KW_FULL[i]) k = K_KEYWORD0 + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### design/slx_front.sv
// ----------------------------------------------------------------------------
// slx_front: byte classifier and scanner state
// Takes one byte per beat, advances the scan state and builds the bundle of
// up to three tokens that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_front #(
  parameter int OFFSET_BITS = slx_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = slx_pkg::LINE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  output slx_pkg::bundle_t      bundle,
  output logic                  push
);
  import slx_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  scan_mode_t              mode_r, mode_nxt;
  logic [1:0]              pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt;
  logic [OFFSET_BITS-1:0]  tok_r, tok_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;
  logic [47:0]             kb_r, kb_nxt;
  logic                    ov_r, ov_nxt;

  logic [OFFSET_BITS-1:0]  pos, endp, dp;
  logic                    used;
  logic                    cv [NUM_CAND];
  token_t                  ct [NUM_CAND];
  logic [2:0]              cnt;

  function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                                  input logic [OFFSET_BITS-1:0] b);
    return (b > a) ? (b - a) : '0;
  endfunction

  function automatic token_t mk(input logic [5:0] k, input logic [1:0] e,
                                input logic [OFFSET_BITS-1:0] s,
                                input logic [OFFSET_BITS-1:0] l,
                                input logic [LINE_BITS-1:0] ln);
    token_t t;
    t.kind  = k;
    t.err   = e;
    t.start = FIELD_BITS'(s);
    t.len   = FIELD_BITS'(l);
    t.line  = FIELD_BITS'(ln);
    return t;
  endfunction

  // scanner: mode step, relex of an unused byte, then end of text
  always_comb begin
    pos      = off_r;
    endp     = (off_r == OFF_MAX) ? OFF_MAX : off_r + OFFSET_BITS'(1);
    dp       = (off_r != '0) ? off_r - OFFSET_BITS'(1) : '0;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    tok_nxt  = tok_r;
    line_nxt = line_r;
    kb_nxt   = kb_r;
    ov_nxt   = ov_r;
    used     = 1'b1;
    for (int i = 0; i < NUM_CAND; i++) begin
      cv[i] = 1'b0;
      ct[i] = '0;
    end

    // mode step (candidates 0 and 1)
    unique case (mode_r)
      M_OP: begin
        if (byte_i == CH_EQUAL) begin
          cv[0] = 1'b1;
          ct[0] = mk(K_OP0 + {3'b0, pend_r, 1'b1}, E_NONE, tok_r, OFFSET_BITS'(2), line_r);
          mode_nxt = M_IDLE;
        end else begin
          cv[0] = 1'b1;
          ct[0] = mk(K_OP0 + {3'b0, pend_r, 1'b0}, E_NONE, tok_r, OFFSET_BITS'(1), line_r);
          used = 1'b0;
        end
      end
      M_SLASH: begin
        if (byte_i == CH_SLASH) mode_nxt = M_COMMENT;
        else begin
          cv[0] = 1'b1;
          ct[0] = mk(K_SLASH, E_NONE, tok_r, OFFSET_BITS'(1), line_r);
          used = 1'b0;
        end
      end
      M_COMMENT: begin
        if (byte_i == CH_NL) used = 1'b0;
      end
      M_STRING: begin
        if (byte_i == CH_QUOTE) begin
          cv[0] = 1'b1;
          ct[0] = mk(K_STRING, E_NONE, tok_r, span(tok_r, pos), line_r);
          mode_nxt = M_IDLE;
        end else if (byte_i == CH_NL) begin
          if (line_r != LINE_MAX) line_nxt = line_r + LINE_ONE;
        end
      end
      M_NUMBER: begin
        if (byte_i == CH_DOT) mode_nxt = M_NUMDOT;
        else if (!is_digit(byte_i)) begin
          cv[0] = 1'b1;
          ct[0] = mk(K_NUMBER, E_NONE, tok_r, span(tok_r, pos), line_r);
          used = 1'b0;
        end
      end
      M_NUMDOT: begin
        if (is_digit(byte_i)) mode_nxt = M_FRACTION;
        else begin
          cv[0] = 1'b1;
          ct[0] = mk(K_NUMBER, E_NONE, tok_r, span(tok_r, dp), line_r);
          cv[1] = 1'b1;
          ct[1] = mk(K_DOT, E_NONE, dp, OFFSET_BITS'(1), line_r);
          used = 1'b0;
        end
      end
      M_FRACTION: begin
        if (!is_digit(byte_i)) begin
          cv[0] = 1'b1;
          ct[0] = mk(K_NUMBER, E_NONE, tok_r, span(tok_r, pos), line_r);
          used = 1'b0;
        end
      end
      M_IDENT: begin
        if (is_alpha(byte_i) || is_digit(byte_i)) begin
          if (kb_r[47:40] != 8'd0) ov_nxt = 1'b1;
          kb_nxt = {kb_r[39:0], byte_i};
        end else begin
          cv[0] = 1'b1;
          ct[0] = mk(ident_kind(kb_r, ov_r), E_NONE, tok_r, span(tok_r, pos), line_r);
          used = 1'b0;
        end
      end
      default: used = 1'b0;
    endcase

    // relex the byte from idle (candidate 2)
    if (!used) begin
      mode_nxt = M_IDLE;
      if (single_valid(byte_i)) begin
        cv[2] = 1'b1;
        ct[2] = mk(single_kind(byte_i), E_NONE, pos, OFFSET_BITS'(1), line_r);
      end else if (byte_i == CH_BANG || byte_i == CH_EQUAL ||
                   byte_i == CH_GT || byte_i == CH_LT) begin
        pend_nxt = (byte_i == CH_BANG)  ? P_BANG :
                   (byte_i == CH_EQUAL) ? P_EQUAL :
                   (byte_i == CH_GT)    ? P_GREATER : P_LESS;
        tok_nxt  = pos;
        mode_nxt = M_OP;
      end else if (byte_i == CH_SLASH) begin
        tok_nxt  = pos;
        mode_nxt = M_SLASH;
      end else if (byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_CR) begin
        mode_nxt = M_IDLE;
      end else if (byte_i == CH_NL) begin
        if (line_r != LINE_MAX) line_nxt = line_r + LINE_ONE;
      end else if (byte_i == CH_QUOTE) begin
        tok_nxt  = endp;
        mode_nxt = M_STRING;
      end else if (is_digit(byte_i)) begin
        tok_nxt  = pos;
        mode_nxt = M_NUMBER;
      end else if (is_alpha(byte_i)) begin
        tok_nxt  = pos;
        kb_nxt   = {40'd0, byte_i};
        ov_nxt   = 1'b0;
        mode_nxt = M_IDENT;
      end else begin
        cv[2] = 1'b1;
        ct[2] = mk(K_LPAREN, E_UNEXP, pos, OFFSET_BITS'(1), line_r);
      end
    end

    off_nxt = endp;

    // end of text: flush the open lexeme (3, 4), end token (5), clear
    if (last_i) begin
      unique case (mode_nxt)
        M_OP: begin
          cv[3] = 1'b1;
          ct[3] = mk(K_OP0 + {3'b0, pend_nxt, 1'b0}, E_NONE, tok_nxt, OFFSET_BITS'(1),
                     line_nxt);
        end
        M_SLASH: begin
          cv[3] = 1'b1;
          ct[3] = mk(K_SLASH, E_NONE, tok_nxt, OFFSET_BITS'(1), line_nxt);
        end
        M_STRING: begin
          cv[3] = 1'b1;
          ct[3] = mk(K_LPAREN, E_UNTERM, tok_nxt, span(tok_nxt, endp), line_nxt);
        end
        M_NUMBER, M_FRACTION: begin
          cv[3] = 1'b1;
          ct[3] = mk(K_NUMBER, E_NONE, tok_nxt, span(tok_nxt, endp), line_nxt);
        end
        M_NUMDOT: begin
          cv[3] = 1'b1;
          ct[3] = mk(K_NUMBER, E_NONE, tok_nxt, span(tok_nxt, pos), line_nxt);
          cv[4] = 1'b1;
          ct[4] = mk(K_DOT, E_NONE, pos, OFFSET_BITS'(1), line_nxt);
        end
        M_IDENT: begin
          cv[3] = 1'b1;
          ct[3] = mk(ident_kind(kb_nxt, ov_nxt), E_NONE, tok_nxt, span(tok_nxt, endp),
                     line_nxt);
        end
        default: cv[3] = 1'b0;
      endcase
      cv[5] = 1'b1;
      ct[5] = mk(K_END, E_NONE, endp, '0, line_nxt);
      mode_nxt = M_IDLE;
      pend_nxt = P_BANG;
      off_nxt  = '0;
      tok_nxt  = '0;
      line_nxt = LINE_ONE;
      kb_nxt   = '0;
      ov_nxt   = 1'b0;
    end
  end

  // pack the first three candidates into the bundle
  always_comb begin
    cnt    = 3'd0;
    bundle = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cv[i] && cnt < 3'(MAX_RES)) begin
        bundle.toks[cnt[1:0]] = ct[i];
        cnt = cnt + 3'd1;
      end
    end
    bundle.cnt = cnt[1:0];
    push       = acc && (cnt != 3'd0);
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= P_BANG;
      off_r  <= '0;
      tok_r  <= '0;
      line_r <= LINE_ONE;
      kb_r   <= '0;
      ov_r   <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      off_r  <= off_nxt;
      tok_r  <= tok_nxt;
      line_r <= line_nxt;
      kb_r   <= kb_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

`default_nettype wire

### design/slx_queue.sv
// ----------------------------------------------------------------------------
// slx_queue: short bundle queue between front and back
// Four-entry FIFO of token bundles; full stalls the byte input.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  slx_pkg::bundle_t       wdata,
  input  wire logic              pop,
  output slx_pkg::bundle_t       rdata,
  output logic                   full,
  output logic                   nonempty
);
  import slx_pkg::*;

  bundle_t                 mem [QDEPTH];
  logic [QPTR_BITS-1:0]    wp_r, wp_nxt;
  logic [QPTR_BITS-1:0]    rp_r, rp_nxt;
  logic [QPTR_BITS:0]      cnt_r, cnt_nxt;
  logic                    do_pop;

  // pointer and fill count
  always_comb begin
    do_pop   = pop && (cnt_r != '0);
    wp_nxt   = push ? wp_r + QPTR_BITS'(1) : wp_r;
    rp_nxt   = do_pop ? rp_r + QPTR_BITS'(1) : rp_r;
    cnt_nxt  = cnt_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(do_pop);
    full     = (cnt_r == (QPTR_BITS+1)'(QDEPTH));
    nonempty = (cnt_r != '0);
    rdata    = mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

`default_nettype wire

### design/slx_back.sv
// ----------------------------------------------------------------------------
// slx_back: token serializer
// Holds one bundle in an output register and hands its tokens out one per
// beat, flagging the final token of the bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  slx_pkg::bundle_t       q_data,
  input  wire logic              q_nonempty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output slx_pkg::token_t        tok,
  output logic                   tok_last
);
  import slx_pkg::*;

  bundle_t     cur_r, cur_nxt;
  logic        vld_r, vld_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        beat, at_end;

  // advance through the bundle, refill from the queue
  always_comb begin
    beat     = vld_r && !out_stall;
    at_end   = (idx_r == cur_r.cnt - 2'd1);
    q_pop    = q_nonempty && (!vld_r || (beat && at_end));
    cur_nxt  = cur_r;
    vld_nxt  = vld_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      cur_nxt = q_data;
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (beat) begin
      if (at_end) vld_nxt = 1'b0;
      else        idx_nxt = idx_r + 2'd1;
    end
    out_valid = vld_r;
    tok       = cur_r.toks[idx_r];
    tok_last  = at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

`default_nettype wire

### design/script_lexer_top.sv
// ----------------------------------------------------------------------------
// script_lexer_top: streaming lexer for a small scripting language
// Source bytes in, tokens (kind, error, start, length, line) out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one source byte per beat, in_last on the final byte
//   of a text. After that byte all scan state returns to reset and the next
//   byte starts a new text at offset 0, line 1.
//   Output channel out_*: one token per beat; out_last_result marks the
//   final token caused by one input byte. A byte causes zero to three tokens.
//   Throughput: one byte per cycle while the tokens drain at one per cycle;
//   the token output beat is the limit when bytes produce more than one
//   token. A token passes from the scanner through the bundle queue to the
//   output register.
//   A four-bundle queue separates scanner and output; when it is full,
//   in_stall rises. out_stall holds the current token steady and backs up
//   the queue; nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue and returns the scanner
//   to idle at offset 0, line 1.
// ----------------------------------------------------------------------------
`default_nettype none

module script_lexer_top #(
  parameter int OFFSET_BITS = slx_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = slx_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_token_kind,
  output logic [1:0]       out_error_code,
  output logic [23:0]      out_start_offset,
  output logic [23:0]      out_lexeme_length,
  output logic [23:0]      out_line_number,
  output logic             out_last_result
);
  import slx_pkg::*;

  bundle_t  f_bundle, q_data;
  logic     f_push, q_full, q_nonempty, q_pop, acc, tok_last;
  token_t   tok;

  // byte beat
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  slx_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .byte_i (in_byte),
    .last_i (in_last),
    .bundle (f_bundle),
    .push   (f_push)
  );

  slx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wdata    (f_bundle),
    .pop      (q_pop),
    .rdata    (q_data),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  slx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tok        (tok),
    .tok_last   (tok_last)
  );

  // token fields
  assign out_token_kind    = tok.kind;
  assign out_error_code    = tok.err;
  assign out_start_offset  = tok.start;
  assign out_lexeme_length = tok.len;
  assign out_line_number   = tok.line;
  assign out_last_result   = tok_last;

endmodule

`default_nettype wire

### dv/script_lexer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// script_lexer_top_tb: self-checking bench for the streaming lexer
// Drives source bytes with random gaps, predicts every token in a behavioral
// lexer model, and compares each output beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module script_lexer_top_tb;
  import slx_pkg::*;

  // lexer scan states
  typedef enum logic [3:0] {
    S_IDLE, S_OP, S_SLASH, S_COMMENT, S_STRING, S_NUMBER, S_NUMDOT, S_FRACTION, S_IDENT
  } lex_state_t;

  localparam logic [23:0] SAT24    = 24'hFFFFFF;
  localparam int          CYCLE_CAP = 400000;
  localparam int          NUM_ROWS  = 25;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [23:0] start;
    logic [23:0] len;
    logic [23:0] line;
    logic        lst;
  } tok_t;

  // directed stimulus row; chk set where the expected token is typed in
  typedef struct {
    logic [7:0] b;
    logic       l;
    logic       chk;
    tok_t       exp_tok;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic [1:0]  out_error_code;
  logic [23:0] out_start_offset;
  logic [23:0] out_lexeme_length;
  logic [23:0] out_line_number;
  logic        out_last_result;

  script_lexer_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  lex_state_t  lx_state;
  logic [1:0]  lx_pend;
  logic [23:0] lx_pos, lx_tstart, lx_line;
  logic [47:0] lx_kbuf;
  logic        lx_long;
  tok_t        step_toks[$];
  tok_t        token_fifo[$];
  tok_t        pinned_toks[$];
  int          err_count = 0;
  int          tok_seen = 0;
  int          bytes_sent = 0;
  int          cycles = 0;

  task automatic lex_clear();
    lx_state = S_IDLE; lx_pend = P_BANG; lx_pos = '0; lx_tstart = '0; lx_line = 24'd1;
    lx_kbuf = '0; lx_long = 1'b0;
  endtask

  function automatic logic [23:0] span(logic [23:0] a, logic [23:0] b);
    return (b > a) ? b - a : 24'd0;
  endfunction

  function automatic logic [5:0] kw_kind();
    string kw[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                      "or", "print", "return", "super", "this", "true", "var", "while"};
    logic [47:0] v;
    if (lx_long) return K_IDENT;
    for (int i = 0; i < 16; i++) begin
      v = '0;
      for (int j = 0; j < kw[i].len(); j++) v = {v[39:0], kw[i][j]};
      if (v == lx_kbuf) return K_KEYWORD0 + 6'(i);
    end
    return K_IDENT;
  endfunction

  task automatic add_tok(logic [5:0] k, logic [1:0] e, logic [23:0] s, logic [23:0] n);
    tok_t t;
    t = '{kind: k, err: e, start: s, len: n, line: lx_line, lst: 1'b0};
    if (step_toks.size() < 4) step_toks = {step_toks, t};
  endtask

  function automatic int punct_kind(logic [7:0] c);
    case (c)
      CH_LPAREN: return 0;  CH_RPAREN: return 1;  CH_LBRACE: return 2;
      CH_RBRACE: return 3;  CH_COMMA:  return 4;  CH_DOT:    return 5;
      CH_MINUS:  return 6;  CH_PLUS:   return 7;  CH_SEMI:   return 8;
      CH_STAR:   return 10;
      default:   return -1;
    endcase
  endfunction

  function automatic logic dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // advance the lexer model by one byte, queueing its tokens
  task automatic lex_byte(logic [7:0] c, logic l);
    logic [23:0] pos, endp, dp;
    logic        used;
    int          sk, n;
    pos  = lx_pos;
    endp = (pos == SAT24) ? SAT24 : pos + 24'd1;
    used = 1'b1;
    step_toks.delete();
    case (lx_state)
      S_OP:
        if (c == CH_EQUAL) begin
          add_tok(K_OP0 + 6'(2 * lx_pend + 1), E_NONE, lx_tstart, 24'd2);
          lx_state = S_IDLE;
        end else begin
          add_tok(K_OP0 + 6'(2 * lx_pend), E_NONE, lx_tstart, 24'd1); used = 1'b0;
        end
      S_SLASH:
        if (c == CH_SLASH) lx_state = S_COMMENT;
        else begin add_tok(K_SLASH, E_NONE, lx_tstart, 24'd1); used = 1'b0; end
      S_COMMENT: if (c == CH_NL) used = 1'b0;
      S_STRING:
        if (c == CH_QUOTE) begin
          add_tok(K_STRING, E_NONE, lx_tstart, span(lx_tstart, pos)); lx_state = S_IDLE;
        end else if (c == CH_NL && lx_line != SAT24) lx_line++;
      S_NUMBER:
        if (c == CH_DOT) lx_state = S_NUMDOT;
        else if (!dig(c)) begin
          add_tok(K_NUMBER, E_NONE, lx_tstart, span(lx_tstart, pos)); used = 1'b0;
        end
      S_NUMDOT:
        if (dig(c)) lx_state = S_FRACTION;
        else begin
          dp = (pos != 24'd0) ? pos - 24'd1 : 24'd0;
          add_tok(K_NUMBER, E_NONE, lx_tstart, span(lx_tstart, dp));
          add_tok(K_DOT, E_NONE, dp, 24'd1);
          used = 1'b0;
        end
      S_FRACTION:
        if (!dig(c)) begin
          add_tok(K_NUMBER, E_NONE, lx_tstart, span(lx_tstart, pos)); used = 1'b0;
        end
      S_IDENT:
        if (alp(c) || dig(c)) begin
          if (lx_kbuf[47:40] != 8'd0) lx_long = 1'b1;
          lx_kbuf = {lx_kbuf[39:0], c};
        end else begin
          add_tok(kw_kind(), E_NONE, lx_tstart, span(lx_tstart, pos)); used = 1'b0;
        end
      default: used = 1'b0;
    endcase

    // byte not consumed by a pending token: lex it from idle
    if (!used) begin
      lx_state = S_IDLE;
      sk = punct_kind(c);
      if (sk >= 0) add_tok(6'(sk), E_NONE, pos, 24'd1);
      else if (c == CH_BANG || c == CH_EQUAL || c == CH_GT || c == CH_LT) begin
        lx_pend = (c == CH_BANG) ? P_BANG : (c == CH_EQUAL) ? P_EQUAL :
                  (c == CH_GT) ? P_GREATER : P_LESS;
        lx_tstart = pos; lx_state = S_OP;
      end else if (c == CH_SLASH) begin lx_tstart = pos; lx_state = S_SLASH; end
      else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) ;
      else if (c == CH_NL) begin if (lx_line != SAT24) lx_line++; end
      else if (c == CH_QUOTE) begin lx_tstart = endp; lx_state = S_STRING; end
      else if (dig(c)) begin lx_tstart = pos; lx_state = S_NUMBER; end
      else if (alp(c)) begin
        lx_tstart = pos; lx_kbuf = {40'd0, c}; lx_long = 1'b0; lx_state = S_IDENT;
      end else add_tok(K_LPAREN, E_UNEXP, pos, 24'd1);
    end
    lx_pos = endp;

    // flush of the open token and the end token at the end of the text
    if (l) begin
      case (lx_state)
        S_OP:       add_tok(K_OP0 + 6'(2 * lx_pend), E_NONE, lx_tstart, 24'd1);
        S_SLASH:    add_tok(K_SLASH, E_NONE, lx_tstart, 24'd1);
        S_STRING:   add_tok(K_LPAREN, E_UNTERM, lx_tstart, span(lx_tstart, endp));
        S_NUMBER, S_FRACTION:
                    add_tok(K_NUMBER, E_NONE, lx_tstart, span(lx_tstart, endp));
        S_NUMDOT: begin
          add_tok(K_NUMBER, E_NONE, lx_tstart, span(lx_tstart, pos));
          add_tok(K_DOT, E_NONE, pos, 24'd1);
        end
        S_IDENT:    add_tok(kw_kind(), E_NONE, lx_tstart, span(lx_tstart, endp));
        default: ;
      endcase
      add_tok(K_END, E_NONE, endp, 24'd0);
      lex_clear();
    end

    // at most three tokens leave per byte; the last of them carries the marker
    n = (step_toks.size() > 3) ? 3 : step_toks.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) step_toks[i].lst = 1'b1;
      token_fifo = {token_fifo, step_toks[i]};
    end
  endtask

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    err_count++;
    $display("MISMATCH token %0d %s: got %0d expected %0d", tok_seen, what, got, want);
  endtask

  // output side: random stalls, compare each beat with the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    tok_t e;
    if (rst_n) begin
      cycles++;
      if (out_valid && !out_stall) begin
        if (token_fifo.size() == 0) begin
          report_mismatch("unexpected token kind", 24'(out_token_kind), 24'd0);
        end else begin
          e = token_fifo.pop_front();
          if (out_token_kind != e.kind)
            report_mismatch("kind", 24'(out_token_kind), 24'(e.kind));
          if (out_error_code != e.err)
            report_mismatch("error", 24'(out_error_code), 24'(e.err));
          if (out_start_offset != e.start) report_mismatch("start", out_start_offset, e.start);
          if (out_lexeme_length != e.len) report_mismatch("length", out_lexeme_length, e.len);
          if (out_line_number != e.line) report_mismatch("line", out_line_number, e.line);
          if (out_last_result != e.lst)
            report_mismatch("last", 24'(out_last_result), 24'(e.lst));
          if (pinned_toks.size() > 0) begin
            if (pinned_toks[0] != e) report_mismatch("typed row", 24'd0, 24'd1);
            void'(pinned_toks.pop_front());
          end
        end
        tok_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        out_stall <= (stall_left > 0);
      end else out_stall <= 1'b0;
    end
  end

  // send one byte, with a random idle gap first; valid drops only over a gap
  task automatic send_byte(logic [7:0] b, logic l, int gap_bias);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20) :
          ($urandom_range(0, 3) < gap_bias) ? $urandom_range(1, 2) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_byte <= b; in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte(b, l);
    bytes_sent++;
  endtask

  // random source fragments, mostly well formed
  function automatic logic [7:0] pick_byte();
    string pool = "andclasselsefalseforfunifnilorprintreturnsuperthistruevarwhile_xZ";
    string punct = "()+-*/!=<>;,{}\"\t\r";
    case ($urandom_range(0, 9))
      0, 1:    return pool[$urandom_range(0, pool.len() - 1)];
      2:       return "0" + 8'($urandom_range(0, 9));
      3:       return " ";
      4:       return "\n";
      5:       return ".";
      6:       return punct[$urandom_range(0, punct.len() - 1)];
      7:       return "=";
      8:       return "/";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  row_t rows [NUM_ROWS];

  initial begin
    string words[8] = '{"while", "return", "classy", "superlong", "print", "x9_", "or", "fun"};
    string w;
    lex_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: unexpected bytes, operators, comment, string, numbers, end-of-text flushes
    rows = '{
      '{8'h00, 1'b0, 1'b1, '{K_LPAREN, E_UNEXP, 24'd0, 24'd1, 24'd1, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{K_LPAREN, E_UNEXP, 24'd1, 24'd1, 24'd1, 1'b1}},
      '{"!", 1'b0, 1'b0, '0},
      '{"=", 1'b0, 1'b0, '0},
      '{"<", 1'b0, 1'b0, '0},
      '{">", 1'b0, 1'b0, '0},
      '{"/", 1'b0, 1'b0, '0},
      '{"/", 1'b0, 1'b0, '0},
      '{"q", 1'b0, 1'b0, '0},
      '{"\n", 1'b0, 1'b0, '0},
      '{"\"", 1'b0, 1'b0, '0},
      '{"\n", 1'b0, 1'b0, '0},
      '{"\"", 1'b0, 1'b0, '0},
      '{"7", 1'b0, 1'b0, '0},
      '{".", 1'b0, 1'b0, '0},
      '{"5", 1'b0, 1'b0, '0},
      '{" ", 1'b0, 1'b0, '0},
      '{"4", 1'b0, 1'b0, '0},
      '{".", 1'b0, 1'b0, '0},
      '{"a", 1'b1, 1'b0, '0},
      '{"\"", 1'b0, 1'b0, '0},
      '{"z", 1'b1, 1'b0, '0},
      '{"=", 1'b1, 1'b0, '0},
      '{"8", 1'b0, 1'b0, '0},
      '{".", 1'b1, 1'b0, '0}
    };
    foreach (rows[i]) begin
      if (rows[i].chk) pinned_toks = {pinned_toks, rows[i].exp_tok};
      send_byte(rows[i].b, rows[i].l, 0);
    end
    in_valid <= 1'b0;
    // pinned rows lead the stream; wait until every pin is matched by order or the predictions run out
    while (pinned_toks.size() > 0 && token_fifo.size() > 0) @(posedge clk);

    // drain completely once before the random part
    while (token_fifo.size() > 0 && cycles < CYCLE_CAP) @(posedge clk);

    // random texts: keywords, fragments and noise
    while (bytes_sent < 365 && cycles < CYCLE_CAP) begin
      if ($urandom_range(0, 2) == 0) begin
        w = words[$urandom_range(0, 7)];
        for (int j = 0; j < w.len(); j++) send_byte(w[j], 1'b0, $urandom_range(0, 3));
        send_byte(" ", 1'b0, 1);
      end else
        send_byte(pick_byte(), $urandom_range(0, 24) == 0, $urandom_range(0, 3));
    end
    send_byte(";", 1'b1, 0);
    in_valid <= 1'b0;

    while (token_fifo.size() > 0 && cycles < CYCLE_CAP) @(posedge clk);
    repeat (10) @(posedge clk);
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("script_lexer_top verification failed");
      $finish;
    end else begin
      $display("Sent %0d source bytes, checked %0d tokens, %0d errors",
               bytes_sent, tok_seen, err_count);
      if (err_count == 0 && token_fifo.size() == 0)
        $display("script_lexer_top verification clean");
      else
        $display("script_lexer_top verification failed");
      $finish;
    end
  end

  // hard stop if the stream hangs
  always @(posedge clk) begin
    if (cycles > CYCLE_CAP + 100) begin
      $display("script_lexer_top verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

### script_lexer_top.f
design/slx_pkg.sv
design/slx_front.sv
design/slx_queue.sv
design/slx_back.sv
design/script_lexer_top.sv
dv/script_lexer_top_tb.sv
